// File: sv/ambient_light_dimmer_top_macros.svh
// Assertion macros shared by the dimmer RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef AMBIENT_LIGHT_DIMMER_TOP_MACROS_SVH
`define AMBIENT_LIGHT_DIMMER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALD_ASSERT_SAME(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALD_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: sv/ald_pkg.sv
package ald_pkg;

  localparam int SAMPLES_DEF = 4;

  localparam int ADC_W    = 10;
  localparam int DUTY_W   = 8;
  localparam int TICK_W   = 16;
  localparam int CNT_W    = 4;
  localparam int SUM_W    = 14;
  localparam int PROD_W   = ADC_W + DUTY_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W   = $clog2(DIV_STEPS);
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 3;

  // Register map, one 32-bit word per register.
  typedef enum logic [IDX_W-1:0] {
    REG_USE_SENSOR  = 3'd0,
    REG_MANUAL_DUTY = 3'd1,
    REG_BRIGHT      = 3'd2,
    REG_DARK        = 3'd3,
    REG_DUTY_MAX    = 3'd4,
    REG_DUTY_MIN    = 3'd5,
    REG_PERIOD      = 3'd6
  } reg_idx_t;

  localparam logic              RST_USE_SENSOR  = 1'b1;
  localparam logic [DUTY_W-1:0] RST_MANUAL_DUTY = 8'd185;
  localparam logic [ADC_W-1:0]  RST_BRIGHT      = 10'd200;
  localparam logic [ADC_W-1:0]  RST_DARK        = 10'd450;
  localparam logic [DUTY_W-1:0] RST_DUTY_MAX    = 8'd255;
  localparam logic [DUTY_W-1:0] RST_DUTY_MIN    = 8'd20;
  localparam logic [TICK_W-1:0] RST_PERIOD      = 16'd1000;
  localparam logic [DUTY_W-1:0] RST_SENSOR_DUTY = 8'd255;

  typedef struct packed {
    logic              use_sensor;
    logic [DUTY_W-1:0] manual_duty;
    logic [ADC_W-1:0]  bright_threshold;
    logic [ADC_W-1:0]  dark_threshold;
    logic [DUTY_W-1:0] duty_max;
    logic [DUTY_W-1:0] duty_min;
    logic [TICK_W-1:0] sample_period_ms;
  } cfg_t;

  typedef struct packed {
    logic             cmd;
    logic [ADC_W-1:0] adc_value;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              sample_request;
    logic              duty_updated;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic avg_calc;
    logic div_step;
    logic map_check;
    logic map_finish;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic reading_done;
    logic in_range;
    logic out_free;
  } ctrl_status_t;

endpackage

// File: sv/ald_regs.sv
module ald_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ald_pkg::ADDR_W-1:0]  paddr,
  input  logic [ald_pkg::DATA_W-1:0]  pwdata,
  output logic [ald_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ald_pkg::cfg_t               cfg
);
  import ald_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_sensor       <= RST_USE_SENSOR;
      cfg.manual_duty      <= RST_MANUAL_DUTY;
      cfg.bright_threshold <= RST_BRIGHT;
      cfg.dark_threshold   <= RST_DARK;
      cfg.duty_max         <= RST_DUTY_MAX;
      cfg.duty_min         <= RST_DUTY_MIN;
      cfg.sample_period_ms <= RST_PERIOD;
    end else if (wr) begin
      unique case (idx)
        REG_USE_SENSOR:  cfg.use_sensor       <= pwdata[0];
        REG_MANUAL_DUTY: cfg.manual_duty      <= pwdata[DUTY_W-1:0];
        REG_BRIGHT:      cfg.bright_threshold <= pwdata[ADC_W-1:0];
        REG_DARK:        cfg.dark_threshold   <= pwdata[ADC_W-1:0];
        REG_DUTY_MAX:    cfg.duty_max         <= pwdata[DUTY_W-1:0];
        REG_DUTY_MIN:    cfg.duty_min         <= pwdata[DUTY_W-1:0];
        REG_PERIOD:      cfg.sample_period_ms <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_USE_SENSOR:  prdata = DATA_W'(cfg.use_sensor);
      REG_MANUAL_DUTY: prdata = DATA_W'(cfg.manual_duty);
      REG_BRIGHT:      prdata = DATA_W'(cfg.bright_threshold);
      REG_DARK:        prdata = DATA_W'(cfg.dark_threshold);
      REG_DUTY_MAX:    prdata = DATA_W'(cfg.duty_max);
      REG_DUTY_MIN:    prdata = DATA_W'(cfg.duty_min);
      REG_PERIOD:      prdata = DATA_W'(cfg.sample_period_ms);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: sv/ald_dp.sv
module ald_dp #(
  parameter int unsigned SAMPLES = ald_pkg::SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ald_pkg::cfg_t         cfg,
  input  ald_pkg::in_t          in_item,
  input  ald_pkg::ctrl_cmd_t    cmd,
  output ald_pkg::ctrl_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ald_pkg::out_t         out_item
);
  import ald_pkg::*;

  localparam logic [CNT_W:0] SAMPLES_C = (CNT_W + 1)'(SAMPLES);

  // The average is a multiply by a rounded-up reciprocal of SAMPLES. The rounding
  // error stays below SAMPLES, so with this shift it never reaches the next integer
  // for any sum that fits in SUM_W bits.
  localparam int unsigned         AVG_SHIFT  = SUM_W + CNT_W;
  localparam int unsigned         AVG_PROD_W = SUM_W + AVG_SHIFT + 1;
  localparam logic [AVG_SHIFT:0]  AVG_RECIP  =
    (AVG_SHIFT + 1)'(((1 << AVG_SHIFT) + SAMPLES - 1) / SAMPLES);

  logic [TICK_W-1:0] elapsed;
  logic              collecting;
  logic [CNT_W-1:0]  taken;
  logic [SUM_W-1:0]  sum;
  logic [DUTY_W-1:0] sensor_duty;
  logic              updated;

  // Restoring divider for the interpolation: partial remainder, dividend/quotient,
  // divisor. The dividend register also carries the sum and then the average.
  logic [ADC_W-1:0]  rem;
  logic [PROD_W-1:0] dq;
  logic [ADC_W-1:0]  divisor;
  logic              neg;

  logic [TICK_W-1:0]     elapsed_inc;
  logic [CNT_W:0]        taken_inc;
  logic [SUM_W-1:0]      sum_next;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [ADC_W:0]        shifted;
  logic                  ge;
  logic [ADC_W:0]        diff;
  logic [ADC_W-1:0]      avg;
  logic [ADC_W-1:0]      offset;
  logic [DUTY_W-1:0]     mag;
  logic [PROD_W-1:0]     prod;
  logic                  neg_span;

  assign elapsed_inc = (elapsed != '1) ? elapsed + 1'b1 : elapsed;
  assign taken_inc   = {1'b0, taken} + 1'b1;
  assign sum_next    = sum + SUM_W'(in_item.adc_value);

  assign avg_prod = AVG_PROD_W'(dq[SUM_W-1:0]) * AVG_PROD_W'(AVG_RECIP);

  assign shifted = {rem, dq[PROD_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  assign avg      = dq[ADC_W-1:0];
  assign offset   = avg - cfg.bright_threshold;
  assign neg_span = cfg.duty_min > cfg.duty_max;
  assign mag      = neg_span ? cfg.duty_min - cfg.duty_max : cfg.duty_max - cfg.duty_min;
  assign prod     = PROD_W'(offset) * PROD_W'(mag);

  assign status.reading_done = in_item.cmd && collecting && (taken_inc >= SAMPLES_C);
  assign status.in_range     = (avg > cfg.bright_threshold) && (avg < cfg.dark_threshold);
  assign status.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed     <= '0;
      collecting  <= 1'b0;
      taken       <= '0;
      sum         <= '0;
      sensor_duty <= RST_SENSOR_DUTY;
      updated     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        updated <= status.reading_done;
        if (!in_item.cmd) begin
          if (elapsed_inc >= cfg.sample_period_ms) begin
            elapsed    <= '0;
            collecting <= 1'b1;
            taken      <= '0;
            sum        <= '0;
          end else begin
            elapsed <= elapsed_inc;
          end
        end else if (collecting) begin
          if (status.reading_done) begin
            collecting <= 1'b0;
            taken      <= '0;
            sum        <= '0;
          end else begin
            taken <= taken_inc[CNT_W-1:0];
            sum   <= sum_next;
          end
        end
      end
      if (cmd.map_check && !status.in_range) begin
        sensor_duty <= (avg <= cfg.bright_threshold) ? cfg.duty_max : cfg.duty_min;
      end
      if (cmd.map_finish) begin
        sensor_duty <= neg ? cfg.duty_max + dq[DUTY_W-1:0] : cfg.duty_max - dq[DUTY_W-1:0];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Averaging, divider and output payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept && status.reading_done) begin
      dq <= PROD_W'(sum_next);
    end else if (cmd.avg_calc) begin
      dq <= PROD_W'(avg_prod[AVG_SHIFT +: ADC_W]);
    end else if (cmd.map_check) begin
      rem     <= '0;
      dq      <= prod;
      divisor <= cfg.dark_threshold - cfg.bright_threshold;
      neg     <= neg_span;
    end else if (cmd.div_step) begin
      rem <= ge ? diff[ADC_W-1:0] : shifted[ADC_W-1:0];
      dq  <= {dq[PROD_W-2:0], ge};
    end
    if (cmd.emit) begin
      out_item.duty           <= cfg.use_sensor ? sensor_duty : cfg.manual_duty;
      out_item.sample_request <= collecting;
      out_item.duty_updated   <= updated;
    end
  end

endmodule

// File: sv/ald_ctrl.sv
module ald_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ald_pkg::ctrl_status_t status,
  output ald_pkg::ctrl_cmd_t    cmd
);
  import ald_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_AVG       = 6'b000010,
    S_MAP_CHECK = 6'b000100,
    S_MAP_DIV   = 6'b001000,
    S_MAP_DONE  = 6'b010000,
    S_EMIT      = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic              step_last;

  assign step_last = step == STEP_W'(DIV_STEPS - 1);
  assign in_ready  = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = status.reading_done ? S_AVG : S_EMIT;
        end
      end
      S_AVG: begin
        cmd.avg_calc = 1'b1;
        state_next   = S_MAP_CHECK;
      end
      S_MAP_CHECK: begin
        cmd.map_check = 1'b1;
        state_next    = status.in_range ? S_MAP_DIV : S_EMIT;
      end
      S_MAP_DIV: begin
        cmd.div_step = 1'b1;
        if (step_last) begin
          state_next = S_MAP_DONE;
        end
      end
      S_MAP_DONE: begin
        cmd.map_finish = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= cmd.div_step && !step_last ? step + 1'b1 : '0;
    end
  end

endmodule

// File: sv/ambient_light_dimmer_top.sv
// Channel   Handshake               Payload   Direction
// input     in_valid / in_ready     in_item   tick or sensor reading in
// output    out_valid / out_ready   out_item  duty, request and update flags out
// config    psel/penable/pwrite     pwdata    APB register write, prdata read
//
// A tick, or a reading that does not finish a set, goes from idle straight to emit.
// A set-ending reading then passes the averaging and map-check states, and inside the
// thresholds 18 steps of the one-bit-per-cycle divider interpolate before map-done.
// Synchronous active-high reset restores all but the divider and payload registers.
// A stalled output holds its transaction while the next input is still taken in;
// the controller then waits in its emit state until the output frees up.
module ambient_light_dimmer_top #(
  parameter int unsigned SAMPLES = ald_pkg::SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ald_pkg::in_t               in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ald_pkg::out_t              out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ald_pkg::ADDR_W-1:0] paddr,
  input  logic [ald_pkg::DATA_W-1:0] pwdata,
  output logic [ald_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ald_pkg::*;

`include "ambient_light_dimmer_top_macros.svh"

  cfg_t         cfg;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Configuration registers behind the APB port.
  ald_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller sequences one transaction at a time.
  ald_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the tick counter, the reading accumulator, the averaging
  // multiplier, the divider and the output register.
  ald_dp #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // The block works on one transaction at a time, so it is busy right after taking one.
  `ALD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                   "input taken while previous transaction still in progress")

  // Finishing a set of readings always ends the collection window.
  `ALD_ASSERT_SAME(a_update_ends_request, out_valid && out_item.duty_updated,
                   !out_item.sample_request, "duty update with request still raised")

  // In manual mode the delivered duty is the manual register.
  `ALD_ASSERT_SAME(a_manual_duty, out_valid && !cfg.use_sensor,
                   out_item.duty == cfg.manual_duty, "manual duty not delivered")

endmodule

// File: bench/dimmer_tb_pkg.sv
`timescale 1ns / 100ps
package dimmer_tb_pkg;

  // Kind of input transaction carried in in_item.cmd.
  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_READING = 1'b1
  } dimmer_cmd_e;

endpackage

// File: bench/dimmer_checker.sv
`timescale 1ns / 100ps
module dimmer_checker #(
  parameter int SAMPLES = ald_pkg::SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  ald_pkg::in_t               in_item,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  ald_pkg::out_t              out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [ald_pkg::ADDR_W-1:0] paddr,
  input  logic [ald_pkg::DATA_W-1:0] pwdata,
  output int                         mismatch_count,
  output int                         results_due,
  output int                         updates_seen
);
  import ald_pkg::*;
  import dimmer_tb_pkg::*;

  cfg_t              cfg;
  logic [TICK_W-1:0] ticks_since_request;
  logic              collecting;
  logic [CNT_W-1:0]  readings_in;
  logic [SUM_W-1:0]  light_sum;
  logic [DUTY_W-1:0] sensor_duty;
  out_t              duty_results_due[$];
  int                mismatches;
  int                n_updates;

  // Map an averaged reading onto the duty range; the middle band is interpolated
  // with signed arithmetic so that duty_min above duty_max still truncates toward zero.
  function automatic logic [DUTY_W-1:0] interp_duty(input logic [ADC_W-1:0] avg);
    int offset;
    int span;
    int val;
    if (avg <= cfg.bright_threshold) return cfg.duty_max;
    if (avg >= cfg.dark_threshold) return cfg.duty_min;
    offset = int'(avg) - int'(cfg.bright_threshold);
    span   = int'(cfg.duty_max) - int'(cfg.duty_min);
    val    = int'(cfg.duty_max) -
             (offset * span) / (int'(cfg.dark_threshold) - int'(cfg.bright_threshold));
    return val[DUTY_W-1:0];
  endfunction

  function automatic out_t next_duty_result(input in_t item);
    out_t             res;
    logic [SUM_W-1:0] total;
    res.duty_updated = 1'b0;
    if (item.cmd == CMD_TICK) begin
      if (ticks_since_request != '1) ticks_since_request++;
      if (ticks_since_request >= cfg.sample_period_ms) begin
        ticks_since_request = '0;
        collecting          = 1'b1;
        readings_in         = '0;
        light_sum           = '0;
      end
    end else if (collecting) begin
      total = light_sum + SUM_W'(item.adc_value);
      if (int'(readings_in) + 1 >= SAMPLES) begin
        sensor_duty      = interp_duty(ADC_W'(total / SAMPLES));
        collecting       = 1'b0;
        readings_in      = '0;
        light_sum        = '0;
        res.duty_updated = 1'b1;
      end else begin
        readings_in = readings_in + 1'b1;
        light_sum   = total;
      end
    end
    res.duty           = cfg.use_sensor ? sensor_duty : cfg.manual_duty;
    res.sample_request = collecting;
    return res;
  endfunction

  task automatic flag_field(input string field, input logic [DUTY_W-1:0] want,
                            input logic [DUTY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      cfg = '{use_sensor: RST_USE_SENSOR, manual_duty: RST_MANUAL_DUTY,
              bright_threshold: RST_BRIGHT, dark_threshold: RST_DARK,
              duty_max: RST_DUTY_MAX, duty_min: RST_DUTY_MIN,
              sample_period_ms: RST_PERIOD};
      ticks_since_request = '0;
      collecting          = 1'b0;
      readings_in         = '0;
      light_sum           = '0;
      sensor_duty         = RST_SENSOR_DUTY;
      duty_results_due.delete();
      mismatches = 0;
      n_updates  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_USE_SENSOR:  cfg.use_sensor       = pwdata[0];
          REG_MANUAL_DUTY: cfg.manual_duty      = pwdata[DUTY_W-1:0];
          REG_BRIGHT:      cfg.bright_threshold = pwdata[ADC_W-1:0];
          REG_DARK:        cfg.dark_threshold   = pwdata[ADC_W-1:0];
          REG_DUTY_MAX:    cfg.duty_max         = pwdata[DUTY_W-1:0];
          REG_DUTY_MIN:    cfg.duty_min         = pwdata[DUTY_W-1:0];
          REG_PERIOD:      cfg.sample_period_ms = pwdata[TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) duty_results_due.push_back(next_duty_result(in_item));
      if (out_valid && out_ready) begin
        if (duty_results_due.size() == 0) begin
          $display("%0t: result with none expected, got duty %0d request %b updated %b",
                   $time, out_item.duty, out_item.sample_request, out_item.duty_updated);
          mismatches++;
        end else begin
          want = duty_results_due.pop_front();
          flag_field("duty", want.duty, out_item.duty);
          flag_field("sample_request", DUTY_W'(want.sample_request),
                     DUTY_W'(out_item.sample_request));
          flag_field("duty_updated", DUTY_W'(want.duty_updated),
                     DUTY_W'(out_item.duty_updated));
          if (want.duty_updated) n_updates++;
        end
      end
    end
    mismatch_count <= mismatches;
    results_due    <= duty_results_due.size();
    updates_seen   <= n_updates;
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import ald_pkg::*;
  import dimmer_tb_pkg::*;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_item;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int results_due;
  int updates_seen;

  // Stimulus bookkeeping. The threshold and period copies only steer what readings
  // and how many ticks are sent; they play no part in the checking.
  int                sender_idle_pct = 0;
  int                recv_stall_pct  = 0;
  int                items_sent      = 0;
  int                settings_used   = 0;
  logic [ADC_W-1:0]  cur_bright      = RST_BRIGHT;
  logic [ADC_W-1:0]  cur_dark        = RST_DARK;
  logic [TICK_W-1:0] cur_period      = RST_PERIOD;

  ambient_light_dimmer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // The checker sees every channel exactly as the block does and keeps its own
  // model of the dimmer, so this module only has to generate traffic.
  dimmer_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatch_count(mismatch_count), .results_due(results_due),
    .updates_seen(updates_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver decides afresh each cycle whether it will take a transaction.
  always @(posedge clk)
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  // Each call starts just after the clock rises. Valid is left high after acceptance
  // so that consecutive transactions need no extra assignment; a gap lowers it.
  task automatic send(input dimmer_cmd_e kind, input logic [ADC_W-1:0] value);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{cmd: kind, adc_value: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // One APB write: setup cycle, then access cycle until pready is seen.
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only once the block has returned every outstanding result.
  // Every transaction yields exactly one result, so an empty queue means idle.
  task automatic program_dimmer(input logic use_sensor, input logic [DUTY_W-1:0] manual,
                                input logic [ADC_W-1:0] bright, input logic [ADC_W-1:0] dark,
                                input logic [DUTY_W-1:0] dmax, input logic [DUTY_W-1:0] dmin,
                                input logic [TICK_W-1:0] period);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    write_reg(REG_USE_SENSOR, DATA_W'(use_sensor));
    write_reg(REG_MANUAL_DUTY, DATA_W'(manual));
    write_reg(REG_BRIGHT, DATA_W'(bright));
    write_reg(REG_DARK, DATA_W'(dark));
    write_reg(REG_DUTY_MAX, DATA_W'(dmax));
    write_reg(REG_DUTY_MIN, DATA_W'(dmin));
    write_reg(REG_PERIOD, DATA_W'(period));
    cur_bright = bright;
    cur_dark   = dark;
    cur_period = period;
    settings_used++;
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin
        sender_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      1: begin
        sender_idle_pct = 60;
        recv_stall_pct <= 0;
      end
      2: begin
        sender_idle_pct = 0;
        recv_stall_pct <= 60;
      end
      default: begin
        sender_idle_pct = 6;
        recv_stall_pct <= 6;
      end
    endcase
  endtask

  // A reading near the given level, clipped to the converter range.
  function automatic logic [ADC_W-1:0] reading_near(input int level);
    int v;
    v = level + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > (1 << ADC_W) - 1) v = (1 << ADC_W) - 1;
    return v[ADC_W-1:0];
  endfunction

  // A full sample cycle: enough ticks to raise a request from any count, then one
  // complete set of readings. About a third of the sets are fully random; the rest
  // sit between the thresholds, where the interpolation is exercised.
  task automatic run_reading_set();
    int level;
    bit anywhere;
    repeat (cur_period == 0 ? 1 : int'(cur_period)) send(CMD_TICK, ADC_W'($urandom));
    anywhere = ($urandom_range(2) == 0);
    level    = $urandom_range(cur_bright, cur_dark);
    repeat (SAMPLES_DEF) begin
      if (anywhere) send(CMD_READING, ADC_W'($urandom));
      else send(CMD_READING, reading_near(level));
    end
  endtask

  // Mostly well-formed sample cycles, mixed with loose ticks, stray readings and
  // sets cut short. With a very long period only loose traffic makes sense.
  task automatic run_phase(input int n_items, input int mode);
    int start;
    set_idling(mode);
    start = items_sent;
    while (items_sent - start < n_items) begin
      if (cur_period > 64)
        send(($urandom_range(3) == 0) ? CMD_READING : CMD_TICK, ADC_W'($urandom));
      else if ($urandom_range(99) < 85)
        run_reading_set();
      else
        repeat ($urandom_range(1, 3))
          send(dimmer_cmd_e'($urandom_range(1)), ADC_W'($urandom));
    end
  endtask

  initial begin
    int               phase;
    logic [ADC_W-1:0] b;
    logic [ADC_W-1:0] d;
    logic [ADC_W-1:0] t;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: readings with no request pending are dropped, and a tick
    // carrying a full-scale value must ignore it.
    send(CMD_READING, '1);
    send(CMD_TICK, '1);
    send(CMD_READING, '0);

    // Short period with reset thresholds: dark average, an interrupted set that
    // restarts, bright average, and one average in the interpolation band.
    program_dimmer(1'b1, RST_MANUAL_DUTY, RST_BRIGHT, RST_DARK, RST_DUTY_MAX,
                   RST_DUTY_MIN, 16'd2);
    repeat (2) send(CMD_TICK, '0);
    repeat (4) send(CMD_READING, '1);
    repeat (2) send(CMD_TICK, '0);
    repeat (3) send(CMD_READING, '0);
    repeat (2) send(CMD_TICK, '0);
    repeat (4) send(CMD_READING, '0);
    repeat (2) send(CMD_TICK, '0);
    repeat (3) send(CMD_READING, 10'd300);
    send(CMD_READING, 10'd301);

    // Fixed corner settings: manual duty at both ends, full threshold span,
    // crossed thresholds with a zero period, inverted duty range, then a huge
    // period followed by one lowered below the count already reached.
    program_dimmer(1'b0, 8'd0, 10'd200, 10'd450, 8'd255, 8'd20, 16'd1);
    run_phase(120, 0);
    program_dimmer(1'b0, 8'd255, 10'd0, 10'd1023, 8'd255, 8'd0, 16'd2);
    run_phase(120, 1);
    program_dimmer(1'b1, 8'd185, 10'd0, 10'd1023, 8'd255, 8'd0, 16'd1);
    run_phase(120, 2);
    program_dimmer(1'b1, 8'd185, 10'd1023, 10'd0, 8'd200, 8'd50, 16'd0);
    run_phase(120, 3);
    program_dimmer(1'b1, 8'd185, 10'd100, 10'd900, 8'd0, 8'd255, 16'd3);
    run_phase(120, 0);
    program_dimmer(1'b1, 8'd185, 10'd300, 10'd700, 8'd255, 8'd0, 16'd65535);
    run_phase(60, 1);
    program_dimmer(1'b1, 8'd185, 10'd300, 10'd700, 8'd180, 8'd60, 16'd4);
    run_phase(120, 2);

    // Random settings until the item budget is spent; most keep bright below
    // dark, a few cross them.
    phase = 3;
    while (items_sent < 1850) begin
      b = ADC_W'($urandom);
      d = ADC_W'($urandom);
      if ($urandom_range(4) != 0 && b > d) begin
        t = b;
        b = d;
        d = t;
      end
      program_dimmer($urandom_range(3) != 0, DUTY_W'($urandom), b, d,
                     DUTY_W'($urandom), DUTY_W'($urandom), TICK_W'($urandom_range(8)));
      run_phase(150, phase);
      phase++;
    end

    // Drain, then give the block time to show any result it should not produce.
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Run covered %0d input transactions under %0d register settings, %0d completed reading sets.",
             items_sent, settings_used, updates_seen);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timed out with %0d results still outstanding.", results_due);
    $display("== FAIL ==");
    $finish;
  end

endmodule
